/* rtl/glyph_text_blitter_top_defines.svh */
// Assertion macros shared by the glyph text blitter RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef GLYPH_TEXT_BLITTER_TOP_DEFINES_SVH
`define GLYPH_TEXT_BLITTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define GTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GTB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GTB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GTB_ASSERT(lbl, prop, msg)
`define GTB_ASSERT_IMP(lbl, ante, cons, msg)
`define GTB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/gtb_pkg.sv */
// Shared types and constants for the glyph text blitter.
// Used by gtb_ctrl, gtb_datapath and glyph_text_blitter_top; no dependencies.
`default_nettype none

package gtb_pkg;

	localparam int STORE_AW   = 14;   // font store address bits
	localparam int PIX_W      = 32;
	localparam int CODE_W     = 8;
	localparam int COORD_W    = 12;
	localparam int PITCH_W    = 13;
	localparam int GPR_W      = 5;
	localparam int DADDR_W    = 24;
	localparam int CFG_AW     = 3;
	localparam int CFG_DW     = 32;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 56;
	localparam int M_TUSER_W  = 2;

	localparam logic [CODE_W-1:0] CODE_NUL     = 8'd0;
	localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_CHAR = 1'b1;

	localparam logic [CFG_AW-1:0] CFG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_PITCH     = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_GPR       = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_KEY_EN    = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_KEY_COLOR = 3'd5;

	// one quotient bit per divider step
	localparam int DIV_CNT_W = 3;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'(CODE_W - 1);

	typedef struct packed {
		logic font_wr;    // store the accepted font pixel
		logic char_acc;   // character beat accepted: cursor update, divider load
		logic div_step;   // one restoring division step
		logic setup;      // form glyph and framebuffer bases, advance cursor
		logic issue;      // read one font pixel into the pixel pipe
	} gtb_cmd_t;

	typedef struct packed {
		logic in_load;    // input beat is a font load
		logic in_glyph;   // input beat is a drawable character
		logic s1_ready;   // pixel pipe can take a read this cycle
		logic pix_last;   // pixel counters sit on the final glyph pixel
	} gtb_sts_t;

endpackage

`default_nettype wire

/* rtl/gtb_ctrl.sv */
// Controller state machine of the glyph text blitter.
// Depends on gtb_pkg and the assertion macros in glyph_text_blitter_top_defines.svh.
`default_nettype none
`include "glyph_text_blitter_top_defines.svh"

module gtb_ctrl
	import gtb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire gtb_sts_t sts,
	output gtb_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_SETUP = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.font_wr  = acc && sts.in_load;
		cmd.char_acc = acc && !sts.in_load;
		case (state_q)
			ST_IDLE: begin
				if (acc && sts.in_glyph) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.issue = sts.s1_ready;
				if (sts.s1_ready && sts.pix_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	`GTB_ASSERT_IMP(a_issue_in_emit, cmd.issue, state_q == ST_EMIT, "pixel read outside emit")
	`GTB_ASSERT_NXT(a_div_to_setup, state_q == ST_DIV && div_cnt_q == DIV_LAST, state_q == ST_SETUP, "divider did not finish in time")
	`GTB_ASSERT_NXT(a_emit_done, state_q == ST_EMIT && cmd.issue && sts.pix_last, state_q == ST_IDLE, "glyph end did not return to idle")

endmodule

`default_nettype wire

/* rtl/gtb_datapath.sv */
// Datapath of the glyph text blitter: config registers, cursor, serial divider,
// font store, pixel pipe and output register. Depends on gtb_pkg and the macros.
`default_nettype none
`include "glyph_text_blitter_top_defines.svh"

module gtb_datapath
	import gtb_pkg::*;
#(
	parameter int GLYPH_W = 8,
	parameter int GLYPH_H = 8,
	parameter int FONT_W  = 128,
	parameter int FONT_H  = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_AW-1:0]     cfg_addr,
	input  wire logic [CFG_DW-1:0]     cfg_wdata,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic [M_TUSER_W-1:0]       m_tuser,
	output logic                       m_tlast,
	input  wire gtb_cmd_t              cmd,
	output gtb_sts_t                   sts
);

	localparam int CX_W = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
	localparam int CY_W = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
	localparam logic [CX_W-1:0] CX_LAST = CX_W'(GLYPH_W - 1);
	localparam logic [CY_W-1:0] CY_LAST = CY_W'(GLYPH_H - 1);
	localparam int GX_W = 8;    // 30 * 8 at most
	localparam int GY_W = 11;   // 255 * 8 at most
	localparam int FP_W = GY_W + STORE_AW;

	// input beat fields
	logic [STORE_AW-1:0] in_font_addr;
	logic [PIX_W-1:0]    in_font_pixel;
	logic [CODE_W-1:0]   in_code;
	logic                in_start;

	assign in_font_addr  = s_tdata[13:0];
	assign in_font_pixel = s_tdata[45:14];
	assign in_code       = s_tdata[53:46];
	assign in_start      = s_tdata[54];

	// configuration
	logic [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [GPR_W-1:0]   gpr_cfg_q;
	logic               key_en_q;
	logic [PIX_W-1:0]   key_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			pitch_q     <= 13'd640;
			gpr_cfg_q   <= 5'd16;
			key_en_q    <= 1'b0;
			key_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ORIGIN_X:  origin_x_q  <= cfg_wdata[COORD_W-1:0];
				CFG_ORIGIN_Y:  origin_y_q  <= cfg_wdata[COORD_W-1:0];
				CFG_PITCH:     pitch_q     <= cfg_wdata[PITCH_W-1:0];
				CFG_GPR:       gpr_cfg_q   <= cfg_wdata[GPR_W-1:0];
				CFG_KEY_EN:    key_en_q    <= cfg_wdata[0];
				CFG_KEY_COLOR: key_color_q <= cfg_wdata[PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// status toward the controller
	logic s1_valid_q, out_valid_q, out_free, s1_load, out_load;
	logic [CX_W-1:0] cx_q;
	logic [CY_W-1:0] cy_q;

	assign out_free = !out_valid_q || m_tready;
	assign out_load = s1_valid_q && out_free;
	assign s1_load  = cmd.issue;

	always_comb begin
		sts          = '0;
		sts.in_load  = (s_tuser == KIND_LOAD);
		sts.in_glyph = (s_tuser == KIND_CHAR) && (in_code != CODE_NUL)
			&& (in_code != CODE_NEWLINE);
		sts.s1_ready = !s1_valid_q || out_free;
		sts.pix_last = (cx_q == CX_LAST) && (cy_q == CY_LAST);
	end

	// cursor
	logic [COORD_W-1:0] cur_x_q, cur_y_q, base_x, base_y;

	assign base_x = in_start ? origin_x_q : cur_x_q;
	assign base_y = in_start ? origin_y_q : cur_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (cmd.char_acc) begin
			if (in_code == CODE_NEWLINE) begin
				cur_x_q <= origin_x_q;
				cur_y_q <= base_y + COORD_W'(GLYPH_H);
			end else if (in_code == CODE_NUL) begin
				cur_x_q <= base_x + COORD_W'(GLYPH_W);
				cur_y_q <= base_y;
			end else begin
				cur_x_q <= base_x;
				cur_y_q <= base_y;
			end
		end else if (cmd.setup) begin
			cur_x_q <= cur_x_q + COORD_W'(GLYPH_W);
		end
	end

	// restoring divider: code / glyphs_per_row, one quotient bit per step
	logic [CODE_W-1:0] quo_q;
	logic [GPR_W-1:0]  rem_q, div_q;
	logic [GPR_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[CODE_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.char_acc) begin
			quo_q <= in_code;
			rem_q <= '0;
			div_q <= (gpr_cfg_q == '0) ? GPR_W'(1) : gpr_cfg_q;
		end else if (cmd.div_step) begin
			rem_q <= fits ? GPR_W'(trial - {1'b0, div_q}) : trial[GPR_W-1:0];
			quo_q <= {quo_q[CODE_W-2:0], fits};
		end
	end

	// glyph bases, formed once per character
	logic [GX_W-1:0]     gx;
	logic [GY_W-1:0]     gy;
	logic [FP_W-1:0]     fprod;
	logic [DADDR_W:0]    dprod;
	logic [STORE_AW-1:0] frow_q;
	logic [DADDR_W-1:0]  drow_q;
	logic                missing_q;

	assign gx    = GX_W'(rem_q * GX_W'(GLYPH_W));
	assign gy    = GY_W'(quo_q * GY_W'(GLYPH_H));
	assign fprod = FP_W'(gy) * FP_W'(FONT_W);
	assign dprod = (DADDR_W + 1)'(cur_y_q) * (DADDR_W + 1)'(pitch_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			frow_q    <= fprod[STORE_AW-1:0] + STORE_AW'(gx);
			drow_q    <= dprod[DADDR_W-1:0] + DADDR_W'(cur_x_q);
			missing_q <= (GY_W + 1)'(gy) + (GY_W + 1)'(GLYPH_H) > (GY_W + 1)'(FONT_H);
		end else if (s1_load && cx_q == CX_LAST) begin
			frow_q <= frow_q + STORE_AW'(FONT_W);
			drow_q <= drow_q + DADDR_W'(pitch_q);
		end
	end

	// pixel counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.setup) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (s1_load) begin
			if (cx_q == CX_LAST) begin
				cx_q <= '0;
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

	// font store: one write port, one registered read port
	logic [PIX_W-1:0]    font_mem [2**STORE_AW];
	logic [PIX_W-1:0]    rd_s1;
	logic [STORE_AW-1:0] rd_addr;

	assign rd_addr = frow_q + STORE_AW'(cx_q);

	always_ff @(posedge clk) begin
		if (cmd.font_wr) begin
			font_mem[in_font_addr] <= in_font_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			rd_s1 <= font_mem[rd_addr];
		end
	end

	// pixel pipe stage 1: read in flight
	logic [DADDR_W-1:0] daddr_s1;
	logic               last_s1, missing_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_load) begin
			s1_valid_q <= 1'b1;
		end else if (out_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			daddr_s1   <= drow_q + DADDR_W'(cx_q);
			last_s1    <= sts.pix_last;
			missing_s1 <= missing_q;
		end
	end

	// output register
	logic [DADDR_W-1:0] out_daddr_q;
	logic [PIX_W-1:0]   out_color_q;
	logic               out_we_q, out_missing_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_daddr_q   <= daddr_s1;
			out_color_q   <= missing_s1 ? '0 : rd_s1;
			out_we_q      <= !missing_s1 && !(key_en_q && rd_s1 == key_color_q);
			out_missing_q <= missing_s1;
			out_last_q    <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_color_q, out_daddr_q};
	assign m_tuser  = {out_missing_q, out_we_q};
	assign m_tlast  = out_last_q;

	`GTB_ASSERT_IMP(a_issue_room, s1_load, !s1_valid_q || out_free, "pixel pipe overrun")
	`GTB_ASSERT_IMP(a_missing_blank, out_valid_q && out_missing_q, !out_we_q && out_color_q == '0, "missing glyph pixel not blanked")
	`GTB_ASSERT_NXT(a_out_hold, out_valid_q && !m_tready, out_valid_q, "pending pixel dropped")

endmodule

`default_nettype wire

/* rtl/glyph_text_blitter_top.sv */
// Glyph text blitter. A font-load beat writes one pixel into a 16384 x 32 font
// store; the store has no reset and no clearing pass, so load every font entry
// a glyph will touch before drawing it. A character beat moves the text cursor;
// newline and code zero give no output. A drawable character is accepted, then
// the serial divider splits the code by glyphs_per_row, one quotient bit per
// step, a setup step forms the glyph and framebuffer bases, and the blitter
// emits GLYPH_W*GLYPH_H output pixels (64 with the defaults), one font store
// read per pixel. The output side may stall at any time; the pixel pipe holds
// and resumes. Configuration must be written only while the blitter is idle;
// the block itself does not enforce this.
// Depends on gtb_pkg, gtb_ctrl and gtb_datapath.
`default_nettype none

module glyph_text_blitter_top
	import gtb_pkg::*;
#(
	parameter int GLYPH_W = 8,
	parameter int GLYPH_H = 8,
	parameter int FONT_W  = 128,
	parameter int FONT_H  = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_AW-1:0]     cfg_addr,
	input  wire logic [CFG_DW-1:0]     cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// font_addr[13:0], font_pixel[45:14], char_code[53:46], start_of_text[54], zero
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// kind[0]
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// dest_addr[23:0], color[55:24]
	output logic [M_TDATA_W-1:0]       m_tdata,
	// write_enable[0], glyph_missing[1]
	output logic [M_TUSER_W-1:0]       m_tuser,
	output logic                       m_tlast
);

	gtb_cmd_t cmd;
	gtb_sts_t sts;

	gtb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gtb_datapath #(
		.GLYPH_W (GLYPH_W),
		.GLYPH_H (GLYPH_H),
		.FONT_W  (FONT_W),
		.FONT_H  (FONT_H)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
